FILE: hdl/ri2d_pkg.sv
// ----------------------------------------------------------------------------
// ri2d_pkg: shared types and constants of the 2-D ray intersection block
// Holds the angle format, the CORDIC table, the pipeline widths and the
// item types that pass between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ri2d_pkg;

	// Angle format: the low ANGLE_BITS bits of an angle are a full turn.
	localparam int ANGLE_BITS = 16;

	// CORDIC rotation pipeline.
	localparam int CORDIC_STEPS = 30;
	localparam int CW = 34;
	localparam int ZW = 33;
	localparam int CORD_LAT = CORDIC_STEPS + 1;
	localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
	localparam logic signed [CW-1:0] UNIT_POS = 34'sd1073741824;
	localparam logic signed [CW-1:0] UNIT_NEG = -34'sd1073741824;

	// Arctangent of 2^-i in units of 2^-32 turn.
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
	};

	// Divider: product, divisor and quotient widths.
	localparam int PROD_W = 94;
	localparam int DEN_W = 62;
	localparam int DIV_STEPS = 35;
	localparam int DIV_LAT = DIV_STEPS + 1;
	localparam logic [DIV_STEPS-1:0] OFF_CAP = 35'h4_0000_0000;

	// Queue depths.
	localparam int FQ_DEPTH = 4;
	localparam int FQ_AW = $clog2(FQ_DEPTH);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_AW = $clog2(OQ_DEPTH);

	// Back end pipeline length from queue pop to result push.
	localparam int BACK_LAT = CORD_LAT + 5 + DIV_LAT;

	// Classified request handed from the front end to the back end.
	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y1;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic [1:0]         quad1;
		logic signed [31:0] resid1;
		logic [1:0]         quad2;
		logic signed [31:0] resid2;
	} front_item_t;

	// Finished result.
	typedef struct packed {
		logic signed [31:0] cross_x;
		logic signed [31:0] cross_y;
		logic               parallel;
		logic               overflow;
	} result_t;

endpackage

FILE: hdl/ri2d_front.sv
// ----------------------------------------------------------------------------
// ri2d_front: request intake and classification
// Reduces both angles to a quadrant and a residual, forms the start point
// differences and holds the classified requests in a short queue.
// ----------------------------------------------------------------------------
module ri2d_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic signed [31:0]       start1_x,
	input  logic signed [31:0]       start1_y,
	input  logic [15:0]              dir1_angle,
	input  logic signed [31:0]       start2_x,
	input  logic signed [31:0]       start2_y,
	input  logic [15:0]              dir2_angle,
	input  logic                     fq_pop,
	output logic                     fq_empty,
	output ri2d_pkg::front_item_t    fq_item
);

	localparam int AB = ri2d_pkg::ANGLE_BITS;

	ri2d_pkg::front_item_t item;
	ri2d_pkg::front_item_t mem_q [ri2d_pkg::FQ_DEPTH];
	logic [ri2d_pkg::FQ_AW-1:0] wr_q, rd_q;
	logic [ri2d_pkg::FQ_AW:0] cnt_q;
	logic [AB-1:0] a1, a2;
	logic [31:0] ph1, ph2, sum1, sum2;
	logic do_push, do_pop;

	// Angle to quadrant and signed residual.
	always_comb begin
		a1 = AB'(dir1_angle);
		a2 = AB'(dir2_angle);
		ph1 = {a1, {(32 - AB){1'b0}}};
		ph2 = {a2, {(32 - AB){1'b0}}};
		sum1 = ph1 + 32'h2000_0000;
		sum2 = ph2 + 32'h2000_0000;
		item.quad1 = sum1[31:30];
		item.quad2 = sum2[31:30];
		item.resid1 = $signed(ph1 - {sum1[31:30], 30'd0});
		item.resid2 = $signed(ph2 - {sum2[31:30], 30'd0});
		item.x1 = start1_x;
		item.y1 = start1_y;
		item.dx = 33'(start2_x) - 33'(start1_x);
		item.dy = 33'(start2_y) - 33'(start1_y);
	end

	assign full = (cnt_q == (ri2d_pkg::FQ_AW + 1)'(ri2d_pkg::FQ_DEPTH));
	assign fq_empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = fq_pop && !fq_empty;
	assign fq_item = mem_q[rd_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/ri2d_cordic.sv
// ----------------------------------------------------------------------------
// ri2d_cordic: pipelined cosine and sine
// Thirty rotation stages, then a stage that clamps to the unit and turns
// the pair by the quadrant. Results are Q2.30.
// ----------------------------------------------------------------------------
module ri2d_cordic (
	input  logic               clk,
	input  logic               en,
	input  logic [1:0]         quad,
	input  logic signed [31:0] resid,
	output logic signed [31:0] cos_o,
	output logic signed [31:0] sin_o
);

	localparam int N = ri2d_pkg::CORDIC_STEPS;
	localparam int CW = ri2d_pkg::CW;
	localparam int ZW = ri2d_pkg::ZW;

	logic signed [CW-1:0] x_q [N];
	logic signed [CW-1:0] y_q [N];
	logic signed [ZW-1:0] z_q [N];
	logic [1:0] quad_q [N];
	logic signed [CW-1:0] xc, yc;

	// Rotation stages.
	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [CW-1:0] xi, yi;
		logic signed [ZW-1:0] zi, ai;
		logic [1:0] qi;
		if (i == 0) begin : g_first
			assign xi = ri2d_pkg::CORDIC_X0;
			assign yi = '0;
			assign zi = ZW'(resid);
			assign qi = quad;
		end else begin : g_next
			assign xi = x_q[i-1];
			assign yi = y_q[i-1];
			assign zi = z_q[i-1];
			assign qi = quad_q[i-1];
		end
		assign ai = $signed({1'b0, ri2d_pkg::ATAN_TAB[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				if (zi >= 0) begin
					x_q[i] <= xi - (yi >>> i);
					y_q[i] <= yi + (xi >>> i);
					z_q[i] <= zi - ai;
				end else begin
					x_q[i] <= xi + (yi >>> i);
					y_q[i] <= yi - (xi >>> i);
					z_q[i] <= zi + ai;
				end
				quad_q[i] <= qi;
			end
		end
	end

	// Clamp to the unit circle bound.
	always_comb begin
		xc = x_q[N-1];
		yc = y_q[N-1];
		if (xc > ri2d_pkg::UNIT_POS) begin
			xc = ri2d_pkg::UNIT_POS;
		end else if (xc < ri2d_pkg::UNIT_NEG) begin
			xc = ri2d_pkg::UNIT_NEG;
		end
		if (yc > ri2d_pkg::UNIT_POS) begin
			yc = ri2d_pkg::UNIT_POS;
		end else if (yc < ri2d_pkg::UNIT_NEG) begin
			yc = ri2d_pkg::UNIT_NEG;
		end
	end

	// Quadrant rotation.
	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad_q[N-1])
				2'd0: begin
					cos_o <= xc[31:0];
					sin_o <= yc[31:0];
				end
				2'd1: begin
					cos_o <= -yc[31:0];
					sin_o <= xc[31:0];
				end
				2'd2: begin
					cos_o <= -xc[31:0];
					sin_o <= -yc[31:0];
				end
				default: begin
					cos_o <= yc[31:0];
					sin_o <= -xc[31:0];
				end
			endcase
		end
	end

endmodule

FILE: hdl/ri2d_div.sv
// ----------------------------------------------------------------------------
// ri2d_div: pipelined restoring divider for the ray offset
// A first stage flags quotients of 2^35 or more; then one quotient bit is
// resolved per stage over 35 stages.
// ----------------------------------------------------------------------------
module ri2d_div (
	input  logic                            clk,
	input  logic                            en,
	input  logic [ri2d_pkg::PROD_W-1:0]     prod,
	input  logic [ri2d_pkg::DEN_W-1:0]      den,
	output logic [ri2d_pkg::DIV_STEPS-1:0]  quo,
	output logic                            big
);

	localparam int N = ri2d_pkg::DIV_STEPS;
	localparam int PW = ri2d_pkg::PROD_W;
	localparam int DW = ri2d_pkg::DEN_W;

	logic [DW-1:0] r_q [N+1];
	logic [DW-1:0] d_q [N+1];
	logic [N-1:0] lo_q [N+1];
	logic [N-1:0] q_q [N+1];
	logic big_q [N+1];

	// Range check and initial partial remainder.
	always_ff @(posedge clk) begin
		if (en) begin
			big_q[0] <= ({3'b0, prod} >= {den, {N{1'b0}}});
			r_q[0] <= DW'(prod[PW-1:N]);
			lo_q[0] <= prod[N-1:0];
			d_q[0] <= den;
			q_q[0] <= '0;
		end
	end

	// One quotient bit per stage.
	for (genvar j = 0; j < N; j++) begin : g_bit
		logic [DW:0] r2, df;
		assign r2 = {r_q[j], lo_q[j][N-1-j]};
		assign df = r2 - {1'b0, d_q[j]};
		always_ff @(posedge clk) begin
			if (en) begin
				if (r2 >= {1'b0, d_q[j]}) begin
					r_q[j+1] <= df[DW-1:0];
					q_q[j+1] <= {q_q[j][N-2:0], 1'b1};
				end else begin
					r_q[j+1] <= r2[DW-1:0];
					q_q[j+1] <= {q_q[j][N-2:0], 1'b0};
				end
				lo_q[j+1] <= lo_q[j];
				d_q[j+1] <= d_q[j];
				big_q[j+1] <= big_q[j];
			end
		end
	end

	assign quo = q_q[N];
	assign big = big_q[N];

endmodule

FILE: hdl/ri2d_back.sv
// ----------------------------------------------------------------------------
// ri2d_back: crossing point computation and result queue
// Takes classified requests from the queue, runs trig, determinant,
// numerator, the two divisions and saturation, and buffers the results.
// ----------------------------------------------------------------------------
module ri2d_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fq_empty,
	input  ri2d_pkg::front_item_t  fq_item,
	output logic                   fq_pop,
	output logic                   empty,
	input  logic                   pop,
	output logic signed [31:0]     cross_x,
	output logic signed [31:0]     cross_y,
	output logic                   parallel,
	output logic                   overflow
);

	localparam int LAT = ri2d_pkg::BACK_LAT;
	localparam int CL = ri2d_pkg::CORD_LAT;
	localparam int FL = ri2d_pkg::DIV_LAT + 2;

	typedef struct packed {
		logic signed [31:0] x1;
		logic signed [31:0] y1;
	} start_t;

	typedef struct packed {
		logic signed [32:0] dx;
		logic signed [32:0] dy;
	} diff_t;

	typedef struct packed {
		logic par;
		logic neg_c;
		logic neg_s;
	} flag_t;

	logic adv;
	logic vld_q [LAT];
	start_t xy_q [LAT];
	diff_t dxy_q [CL];
	flag_t flg_q [FL];

	logic signed [31:0] c1, s1, c2, s2;
	logic signed [63:0] p_sc_s32, p_cs_s32;
	logic signed [64:0] p_dc_s32, p_ds_s32;
	logic signed [63:0] det_s33;
	logic signed [64:0] num_s33;
	logic [ri2d_pkg::DEN_W-1:0] ud_s34, ud_s35, ud_s36;
	logic [62:0] un_s34;
	logic [30:0] uc_s34, us_s34;
	flag_t flg_s34;
	logic [62:0] plc_s35, pls_s35;
	logic [61:0] phc_s35, phs_s35;
	logic [ri2d_pkg::PROD_W-1:0] prc_s36, prs_s36;
	logic [63:0] det_abs;
	logic [64:0] num_abs;
	logic [31:0] c1_abs, s1_abs;
	logic signed [31:0] c1_hold_s32, s1_hold_s32, c1_hold_s33, s1_hold_s33;
	logic [ri2d_pkg::DIV_STEPS-1:0] qc, qs;
	logic bigc, bigs;

	ri2d_pkg::result_t res;
	ri2d_pkg::result_t oq_q [ri2d_pkg::OQ_DEPTH];
	logic [ri2d_pkg::OQ_AW-1:0] oq_wr_q, oq_rd_q;
	logic [ri2d_pkg::OQ_AW:0] oq_cnt_q;
	logic oq_push, oq_pop;

	function automatic logic [31:0] c1_dly_abs(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	// Whole pipeline holds when a finished result finds the queue full.
	assign adv = !(vld_q[LAT-1] &&
		(oq_cnt_q == (ri2d_pkg::OQ_AW + 1)'(ri2d_pkg::OQ_DEPTH)));
	assign fq_pop = adv && !fq_empty;

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_q[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_q[0] <= fq_pop;
			for (int k = 1; k < LAT; k++) begin
				vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Side data delay lines.
	always_ff @(posedge clk) begin
		if (adv) begin
			xy_q[0] <= '{x1: fq_item.x1, y1: fq_item.y1};
			for (int k = 1; k < LAT; k++) begin
				xy_q[k] <= xy_q[k-1];
			end
			dxy_q[0] <= '{dx: fq_item.dx, dy: fq_item.dy};
			for (int k = 1; k < CL; k++) begin
				dxy_q[k] <= dxy_q[k-1];
			end
			flg_q[0] <= flg_s34;
			for (int k = 1; k < FL; k++) begin
				flg_q[k] <= flg_q[k-1];
			end
		end
	end

	ri2d_cordic u_trig1 (
		.clk   (clk),
		.en    (adv),
		.quad  (fq_item.quad1),
		.resid (fq_item.resid1),
		.cos_o (c1),
		.sin_o (s1)
	);

	ri2d_cordic u_trig2 (
		.clk   (clk),
		.en    (adv),
		.quad  (fq_item.quad2),
		.resid (fq_item.resid2),
		.cos_o (c2),
		.sin_o (s2)
	);

	// Absolute values for the magnitude path.
	always_comb begin
		det_abs = det_s33[63] ? 64'(-det_s33) : 64'(det_s33);
		num_abs = num_s33[64] ? 65'(-num_s33) : 65'(num_s33);
		c1_abs = c1_dly_abs(c1_hold_s33);
		s1_abs = c1_dly_abs(s1_hold_s33);
	end

	// Cross products, determinant and numerator, then magnitudes and signs, then the dividends.
	always_ff @(posedge clk) begin
		if (adv) begin
			p_sc_s32 <= 64'(s1) * 64'(c2);
			p_cs_s32 <= 64'(c1) * 64'(s2);
			p_dc_s32 <= 65'(dxy_q[CL-1].dy) * 65'(c2);
			p_ds_s32 <= 65'(dxy_q[CL-1].dx) * 65'(s2);
			c1_hold_s32 <= c1;
			s1_hold_s32 <= s1;

			det_s33 <= p_sc_s32 - p_cs_s32;
			num_s33 <= p_dc_s32 - p_ds_s32;
			c1_hold_s33 <= c1_hold_s32;
			s1_hold_s33 <= s1_hold_s32;

			ud_s34 <= det_abs[ri2d_pkg::DEN_W-1:0];
			un_s34 <= num_abs[62:0];
			uc_s34 <= c1_abs[30:0];
			us_s34 <= s1_abs[30:0];
			flg_s34.par <= (det_s33 == '0);
			flg_s34.neg_c <= num_s33[64] ^ c1_hold_s33[31] ^ det_s33[63];
			flg_s34.neg_s <= num_s33[64] ^ s1_hold_s33[31] ^ det_s33[63];

			plc_s35 <= 63'(un_s34[31:0]) * 63'(uc_s34);
			phc_s35 <= 62'(un_s34[62:32]) * 62'(uc_s34);
			pls_s35 <= 63'(un_s34[31:0]) * 63'(us_s34);
			phs_s35 <= 62'(un_s34[62:32]) * 62'(us_s34);
			ud_s35 <= ud_s34;

			prc_s36 <= {phc_s35, 32'd0} + ri2d_pkg::PROD_W'(plc_s35);
			prs_s36 <= {phs_s35, 32'd0} + ri2d_pkg::PROD_W'(pls_s35);
			ud_s36 <= ud_s35;
		end
	end

	ri2d_div u_div_x (
		.clk  (clk),
		.en   (adv),
		.prod (prc_s36),
		.den  (ud_s36),
		.quo  (qc),
		.big  (bigc)
	);

	ri2d_div u_div_y (
		.clk  (clk),
		.en   (adv),
		.prod (prs_s36),
		.den  (ud_s36),
		.quo  (qs),
		.big  (bigs)
	);

	function automatic logic [32:0] add_sat(
		input logic signed [31:0]                 base,
		input logic [ri2d_pkg::DIV_STEPS-1:0]     q,
		input logic                               q_big,
		input logic                               neg
	);
		logic [ri2d_pkg::DIV_STEPS-1:0] mag;
		logic signed [35:0] off;
		logic signed [36:0] sum;
		mag = (q_big || q > ri2d_pkg::OFF_CAP) ? ri2d_pkg::OFF_CAP : q;
		off = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		sum = 37'(base) + 37'(off);
		if (sum > 37'sd2147483647) begin
			return {1'b1, 32'h7FFF_FFFF};
		end else if (sum < -37'sd2147483648) begin
			return {1'b1, 32'h8000_0000};
		end
		return {1'b0, sum[31:0]};
	endfunction

	// Final offset, saturation and the parallel case.
	always_comb begin
		logic [32:0] rx, ry;
		rx = add_sat(xy_q[LAT-1].x1, qc, bigc, flg_q[FL-1].neg_c);
		ry = add_sat(xy_q[LAT-1].y1, qs, bigs, flg_q[FL-1].neg_s);
		if (flg_q[FL-1].par) begin
			res = '{cross_x: '0, cross_y: '0, parallel: 1'b1, overflow: 1'b0};
		end else begin
			res.cross_x = rx[31:0];
			res.cross_y = ry[31:0];
			res.parallel = 1'b0;
			res.overflow = rx[32] | ry[32];
		end
	end

	// Result queue.
	assign oq_push = adv && vld_q[LAT-1];
	assign empty = (oq_cnt_q == '0);
	assign oq_pop = pop && !empty;
	assign cross_x = oq_q[oq_rd_q].cross_x;
	assign cross_y = oq_q[oq_rd_q].cross_y;
	assign parallel = oq_q[oq_rd_q].parallel;
	assign overflow = oq_q[oq_rd_q].overflow;

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q <= '0;
			oq_rd_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) begin
				oq_wr_q <= oq_wr_q + 1'b1;
			end
			if (oq_pop) begin
				oq_rd_q <= oq_rd_q + 1'b1;
			end
			if (oq_push && !oq_pop) begin
				oq_cnt_q <= oq_cnt_q + 1'b1;
			end else if (oq_pop && !oq_push) begin
				oq_cnt_q <= oq_cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/ray_intersection_2d.sv
// ----------------------------------------------------------------------------
// ray_intersection_2d: crossing point of two lines in the plane
//
//   channel   handshake      payload
//   request   push / full    start1_x start1_y dir1_angle
//                            start2_x start2_y dir2_angle
//   result    pop / empty    cross_x cross_y parallel overflow
//
// One request is taken per cycle while full is low. A request passes
// through the request queue, the CORDIC stages, the multiply and
// magnitude stages and the divider stages into the result queue.
// When the result queue is full and a result is ready, the back end holds
// and the front queue fills to four before full rises.
// Reset clears the queues and pipeline valid bits at once; no sweep.
// ----------------------------------------------------------------------------
module ray_intersection_2d (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] start1_x,
	input  logic signed [31:0] start1_y,
	input  logic [15:0]        dir1_angle,
	input  logic signed [31:0] start2_x,
	input  logic signed [31:0] start2_y,
	input  logic [15:0]        dir2_angle,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] cross_x,
	output logic signed [31:0] cross_y,
	output logic               parallel,
	output logic               overflow
);

	logic fq_pop, fq_empty;
	ri2d_pkg::front_item_t fq_item;

	// Front end: intake, classification and request queue.
	ri2d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.start1_x   (start1_x),
		.start1_y   (start1_y),
		.dir1_angle (dir1_angle),
		.start2_x   (start2_x),
		.start2_y   (start2_y),
		.dir2_angle (dir2_angle),
		.fq_pop     (fq_pop),
		.fq_empty   (fq_empty),
		.fq_item    (fq_item)
	);

	// Back end: arithmetic pipeline and result queue.
	ri2d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.fq_empty (fq_empty),
		.fq_item  (fq_item),
		.fq_pop   (fq_pop),
		.empty    (empty),
		.pop      (pop),
		.cross_x  (cross_x),
		.cross_y  (cross_y),
		.parallel (parallel),
		.overflow (overflow)
	);

endmodule
